/* design/cbe_pkg.sv */
package cbe_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int NEWTON_STEPS_DEF = 8;
    localparam int BISECT_STEPS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_X1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y2 = 2'd3;

    localparam logic [16:0] X1_RST = 17'd16384;
    localparam logic [18:0] Y1_RST = 19'sd6554;
    localparam logic [16:0] X2_RST = 17'd16384;
    localparam logic [18:0] Y2_RST = 19'sd65536;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // latch x, build x-axis coefficients, t = x
        OP_EVAL,     // start X(t) and X'(t)
        OP_NSTEP,    // start Newton division
        OP_BINIT,    // bisection: t = x, bounds reset
        OP_BSTEP,    // start X(t) for bisection
        OP_YEVAL     // build y coefficients and start Y(t)
    } op_t;

    typedef struct packed {
        op_t  op;
        logic bis_upd;   // apply bisection bound update
    } cmd_t;

    typedef struct packed {
        logic busy;      // multi-cycle unit still running
        logic err_small; // |X(t)-x| <= 1
        logic d_small;   // |X'(t)| <= 1
        logic lo_ge_hi;  // bisection bounds crossed
    } stat_t;

endpackage

/* design/cubic_bezier_easing_eval.sv */
// channel   direction  handshake           payload
// request   in         start & !busy       progress_x
// result    out        done (one cycle)    eased_y, used_bisection
// config    in         cfg_we              cfg_idx, cfg_data
//
// An out-of-range progress gives its result in the cycle right after the
// request is accepted. Otherwise each Newton step runs the shared multiplier
// and then the bit-serial divider; each bisection step runs the multiplier
// alone, and the final Y runs it once more before the result. Reset restores the
// preset control points. The receiver cannot stall: done lasts exactly one cycle.
module cubic_bezier_easing_eval #(
    parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF,
    parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
    parameter int BISECT_STEPS = cbe_pkg::BISECT_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [17:0]                 progress_x,
    output logic                               done,
    output logic signed [18:0]                 eased_y,
    output logic                               used_bisection,
    input  logic                               cfg_we,
    input  logic [cbe_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [cbe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [16:0]        x1_reg, x2_reg;
    logic signed [18:0] y1_reg, y2_reg;
    logic signed [17:0] px_reg;
    logic               triv_reg;
    logic [18:0]        triv_y_reg;
    cbe_pkg::cmd_t      cmd;
    cbe_pkg::stat_t     stat;
    logic               go, trivial, fin, bis;
    logic signed [18:0] y_dp;

    // write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= cbe_pkg::X1_RST;
            y1_reg <= cbe_pkg::Y1_RST;
            x2_reg <= cbe_pkg::X2_RST;
            y2_reg <= cbe_pkg::Y2_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                cbe_pkg::REG_X1: x1_reg <= cfg_data[16:0];
                cbe_pkg::REG_Y1: y1_reg <= cfg_data;
                cbe_pkg::REG_X2: x2_reg <= cfg_data[16:0];
                cbe_pkg::REG_Y2: y2_reg <= cfg_data;
                default: x1_reg <= x1_reg;
            endcase
        end
    end

    assign go      = start && !busy;
    assign trivial = (progress_x <= 0) || (progress_x >= 18'sd65536);

    // latch the request
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            px_reg     <= progress_x;
            triv_reg   <= trivial;
            triv_y_reg <= (progress_x <= 0) ? 19'd0 : 19'd65536;
        end
    end

    cbe_ctrl #(.NEWTON_STEPS(NEWTON_STEPS), .BISECT_STEPS(BISECT_STEPS)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .trivial (trivial),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy),
        .fin     (fin),
        .bis     (bis)
    );

    cbe_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .px    (px_reg),
        .x1    (x1_reg),
        .y1    (y1_reg),
        .x2    (x2_reg),
        .y2    (y2_reg),
        .stat  (stat),
        .y_out (y_dp)
    );

    assign done           = fin;
    assign eased_y        = triv_reg ? $signed(triv_y_reg) : y_dp;
    assign used_bisection = !triv_reg && bis;

    // a result only comes while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result without request");
    // a result lasts a single cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result longer than one cycle");
    // a trivial request finishes in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && trivial) |=> done)
        else $error("trivial request late");

endmodule

/* design/cbe_ctrl.sv */
module cbe_ctrl #(
    parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
    parameter int BISECT_STEPS = cbe_pkg::BISECT_STEPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  logic           trivial,
    input  cbe_pkg::stat_t stat,
    output cbe_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           fin,
    output logic           bis
);

    localparam int CW = $clog2(BISECT_STEPS + NEWTON_STEPS + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_NEVAL, S_NWAIT, S_NDIV, S_DWAIT,
        S_BINIT, S_BEVAL, S_BWAIT, S_YEVAL, S_YWAIT, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          bis_reg, bis_next;
    cbe_pkg::cmd_t cmd_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bis_next   = bis_reg;
        cmd_next   = '{op: cbe_pkg::OP_NONE, bis_upd: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    bis_next = 1'b0;
                    if (trivial)
                        state_next = S_DONE;
                    else
                    begin
                        cmd_next.op = cbe_pkg::OP_LOAD;
                        cnt_next    = '0;
                        state_next  = S_NEVAL;
                    end
                end
            end
            S_NEVAL:
            begin
                if (cnt_reg == CW'(NEWTON_STEPS))
                    state_next = S_BINIT;
                else
                begin
                    cmd_next.op = cbe_pkg::OP_EVAL;
                    state_next  = S_NWAIT;
                end
            end
            S_NWAIT:
            begin
                if (!stat.busy)
                begin
                    if (stat.err_small)
                    begin
                        cmd_next.op = cbe_pkg::OP_YEVAL;
                        state_next  = S_YWAIT;
                    end
                    else if (stat.d_small)
                        state_next = S_BINIT;
                    else
                        state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                cmd_next.op = cbe_pkg::OP_NSTEP;
                state_next  = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.busy)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_NEVAL;
                end
            end
            S_BINIT:
            begin
                cmd_next.op = cbe_pkg::OP_BINIT;
                bis_next    = 1'b1;
                cnt_next    = '0;
                state_next  = S_BEVAL;
            end
            S_BEVAL:
            begin
                // wait for the bounds to settle before testing them
                if (!stat.busy)
                begin
                    if (cnt_reg == CW'(BISECT_STEPS) || stat.lo_ge_hi)
                        state_next = S_YEVAL;
                    else
                    begin
                        cmd_next.op = cbe_pkg::OP_BSTEP;
                        state_next  = S_BWAIT;
                    end
                end
            end
            S_BWAIT:
            begin
                if (!stat.busy)
                begin
                    if (stat.err_small)
                        state_next = S_YEVAL;
                    else
                    begin
                        cmd_next.bis_upd = 1'b1;
                        cnt_next         = cnt_reg + 1'b1;
                        state_next       = S_BEVAL;
                    end
                end
            end
            S_YEVAL:
            begin
                cmd_next.op = cbe_pkg::OP_YEVAL;
                state_next  = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (!stat.busy)
                    state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // hold state and the registered command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            bis_reg   <= 1'b0;
            cmd       <= '{op: cbe_pkg::OP_NONE, bis_upd: 1'b0};
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bis_reg   <= bis_next;
            cmd       <= cmd_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign fin  = (state_reg == S_DONE);
    assign bis  = bis_reg;

endmodule

/* design/cbe_div.sv */
// Restoring divider: one quotient bit per cycle.
module cbe_div #(
    parameter int NW = 50,
    parameter int DW = 44
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   r_sh;

    assign r_sh = {r_reg[DW-1:0], q_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CW'(NW);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // shift in one numerator bit, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = q_reg;

endmodule

/* design/cbe_dp.sv */
module cbe_dp #(
    parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cbe_pkg::cmd_t       cmd,
    input  logic signed [17:0]  px,
    input  logic [16:0]         x1,
    input  logic signed [18:0]  y1,
    input  logic [16:0]         x2,
    input  logic signed [18:0]  y2,
    output cbe_pkg::stat_t      stat,
    output logic signed [18:0]  y_out
);

    // working width: coefficients reach about 36*ONE in y
    localparam int W  = FRAC_BITS + 8;
    localparam int TW = FRAC_BITS + 2;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
    localparam int NW = 33 + FRAC_BITS;

    typedef enum logic [2:0] {
        M_IDLE, M_B1, M_B2, M_B3, M_B4, M_D1, M_D2
    } mstep_t;

    // rescale a Q16 magnitude into FRAC_BITS fraction bits
    function automatic logic signed [W-1:0] from_q16(input logic signed [19:0] v);
        logic [W+15:0] m;
        logic [W+15:0] s;
        m = (W+16)'(v < 0 ? -v : v);
        if (FRAC_BITS >= 16)
            s = m << (FRAC_BITS - 16);
        else
            s = m >> (16 - FRAC_BITS);
        from_q16 = (v < 0) ? -$signed(W'(s)) : $signed(W'(s));
    endfunction

    // v*t >> FRAC_BITS toward zero, t in [0, ONE]
    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] v,
                                                 input logic [TW-1:0] t);
        logic [W-1:0]    m;
        logic [W+TW-1:0] p;
        logic [W-1:0]    r;
        m = v[W-1] ? W'(-v) : W'(v);
        p = (W+TW)'(m) * (W+TW)'(t);
        r = W'(p >> FRAC_BITS);
        qmul = v[W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [16:0] cx(input logic [16:0] r);
        cx = (r > 17'd65536) ? 17'd65536 : r;
    endfunction

    logic signed [W-1:0] x_reg, a_reg, b_reg, c_reg;
    logic [TW-1:0]       t_reg, lo_reg, hi_reg;
    logic signed [W-1:0] u_reg, acc_reg, err_reg, d_reg;
    logic                ysel_reg;
    mstep_t              ms_reg;
    logic                div_go_reg;
    logic                div_busy;
    logic [NW-1:0]       quo;
    logic                q_neg_reg;
    logic                div_pend_reg;
    logic [NW-1:0]       em;
    logic [W-1:0]        dm;
    logic signed [W-1:0] ax, bx, cxv, ay, by, cy, p1, p2, q1, q2;
    logic signed [W-1:0] mul_o;
    logic signed [W-1:0] mul_a;
    logic signed [NW:0]  t_new;

    assign p1 = from_q16(20'(signed'({1'b0, cx(x1)})));
    assign p2 = from_q16(20'(signed'({1'b0, cx(x2)})));
    assign ax = W'(ONE - 3 * p2 + 3 * p1);
    assign bx = W'(3 * p2 - 6 * p1);
    assign cxv = W'(3 * p1);
    assign q1 = from_q16(20'(y1));
    assign q2 = from_q16(20'(y2));
    assign ay = W'(ONE - 3 * q2 + 3 * q1);
    assign by = W'(3 * q2 - 6 * q1);
    assign cy = W'(3 * q1);

    // one shared multiplier, stepped through M_B1..M_B4 and, for X'(t), M_D1 and M_D2
    always_comb
    begin
        case (ms_reg)
            M_B1:    mul_a = a_reg;
            M_B2:    mul_a = u_reg;
            M_B3:    mul_a = u_reg;
            M_B4:    mul_a = c_reg;
            M_D1:    mul_a = W'(3 * a_reg);
            M_D2:    mul_a = u_reg;
            default: mul_a = '0;
        endcase
    end
    assign mul_o = qmul(mul_a, t_reg);

    assign em = (err_reg[W-1] ? NW'(-err_reg) : NW'(err_reg)) << FRAC_BITS;
    assign dm = d_reg[W-1] ? W'(-d_reg) : W'(d_reg);

    cbe_div #(.NW(NW), .DW(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (em),
        .den   (dm),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign t_new = q_neg_reg ? $signed({1'b0, NW'(t_reg)}) + $signed({1'b0, quo})
                             : $signed({1'b0, NW'(t_reg)}) - $signed({1'b0, quo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg       <= M_IDLE;
            div_go_reg   <= 1'b0;
            div_pend_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= (cmd.op == cbe_pkg::OP_NSTEP);
            if (cmd.op == cbe_pkg::OP_NSTEP)
                div_pend_reg <= 1'b1;
            else if (div_pend_reg && !div_go_reg && !div_busy)
                div_pend_reg <= 1'b0;
            case (ms_reg)
                M_IDLE:
                begin
                    if (cmd.op == cbe_pkg::OP_EVAL || cmd.op == cbe_pkg::OP_BSTEP
                        || cmd.op == cbe_pkg::OP_YEVAL)
                        ms_reg <= M_B1;
                end
                M_B1:    ms_reg <= M_B2;
                M_B2:    ms_reg <= M_B3;
                M_B3:    ms_reg <= M_B4;
                M_B4:    ms_reg <= ysel_reg ? M_D1 : M_IDLE;
                M_D1:    ms_reg <= M_D2;
                M_D2:    ms_reg <= M_IDLE;
                default: ms_reg <= M_IDLE;
            endcase
        end
    end

    // evaluate, step and update t
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cbe_pkg::OP_LOAD:
            begin
                x_reg <= from_q16(20'(px));
                t_reg <= TW'(from_q16(20'(px)));
                a_reg <= ax;
                b_reg <= bx;
                c_reg <= cxv;
            end
            cbe_pkg::OP_BINIT:
            begin
                t_reg  <= TW'(x_reg);
                lo_reg <= '0;
                hi_reg <= TW'(ONE);
            end
            cbe_pkg::OP_YEVAL:
            begin
                a_reg <= ay;
                b_reg <= by;
                c_reg <= cy;
            end
            default:
            begin
            end
        endcase
        if (cmd.op == cbe_pkg::OP_EVAL)
            ysel_reg <= 1'b1;
        else if (cmd.op == cbe_pkg::OP_BSTEP || cmd.op == cbe_pkg::OP_YEVAL)
            ysel_reg <= 1'b0;
        if (cmd.op == cbe_pkg::OP_NSTEP)
            q_neg_reg <= (err_reg < 0) != (d_reg < 0);
        if (cmd.bis_upd)
        begin
            if (x_reg > acc_reg)
            begin
                lo_reg <= t_reg;
                t_reg  <= TW'(({1'b0, t_reg} + {1'b0, hi_reg}) >> 1);
            end
            else
            begin
                hi_reg <= t_reg;
                t_reg  <= TW'(({1'b0, lo_reg} + {1'b0, t_reg}) >> 1);
            end
        end
        if (div_pend_reg && !div_go_reg && !div_busy)
        begin
            if (t_new < 0)
                t_reg <= '0;
            else if (t_new > (NW+1)'(ONE))
                t_reg <= TW'(ONE);
            else
                t_reg <= TW'(t_new);
        end
        case (ms_reg)
            M_B1: u_reg <= mul_o + b_reg;
            M_B2: u_reg <= mul_o;
            M_B3: u_reg <= mul_o;
            M_B4:
            begin
                acc_reg <= u_reg + mul_o;
                err_reg <= u_reg + mul_o - x_reg;
            end
            M_D1: u_reg <= W'(mul_o + 2 * b_reg);
            M_D2: d_reg <= mul_o + c_reg;
            default:
            begin
            end
        endcase
    end

    // a command still in its register counts as work under way
    assign stat.busy = (ms_reg != M_IDLE) || div_pend_reg
                       || (cmd.op != cbe_pkg::OP_NONE) || cmd.bis_upd;
    assign stat.err_small = (err_reg >= -1) && (err_reg <= 1);
    assign stat.d_small = (d_reg >= -1) && (d_reg <= 1);
    assign stat.lo_ge_hi = (lo_reg >= hi_reg);

    // rescale Y to Q16 and saturate
    always_comb
    begin
        logic [W+15:0] m;
        m = (W+16)'(acc_reg[W-1] ? W'(-acc_reg) : W'(acc_reg));
        if (FRAC_BITS >= 16)
            m = m >> (FRAC_BITS - 16);
        else
            m = m << (16 - FRAC_BITS);
        if (!acc_reg[W-1] && m > (W+16)'(262143))
            y_out = 19'sh3FFFF;
        else if (acc_reg[W-1] && m > (W+16)'(262144))
            y_out = 19'sh40000;
        else
            y_out = acc_reg[W-1] ? -19'(m) : 19'(m);
    end

endmodule
